// ===== hdl/stt_pkg.sv =====
// Shared types, character constants and token kind codes for the source text tokenizer.
package stt_pkg;

  localparam int FIELD_BITS = 24;
  localparam int MAX_TOKENS = 3;

  typedef logic [4:0] kind_t;

  localparam kind_t KIND_INT     = 5'd0;
  localparam kind_t KIND_FLOAT   = 5'd1;
  localparam kind_t KIND_STRING  = 5'd2;
  localparam kind_t KIND_IDENT   = 5'd3;
  localparam kind_t KIND_VAR     = 5'd4;
  localparam kind_t KIND_PLUS    = 5'd7;
  localparam kind_t KIND_MINUS   = 5'd8;
  localparam kind_t KIND_STAR    = 5'd9;
  localparam kind_t KIND_SLASH   = 5'd10;
  localparam kind_t KIND_SLASH2  = 5'd11;
  localparam kind_t KIND_LPAREN  = 5'd12;
  localparam kind_t KIND_RPAREN  = 5'd13;
  localparam kind_t KIND_LBRACE  = 5'd14;
  localparam kind_t KIND_RBRACE  = 5'd15;
  localparam kind_t KIND_SEMI    = 5'd16;
  localparam kind_t KIND_ASSIGN  = 5'd17;
  localparam kind_t KIND_COMMA   = 5'd18;
  localparam kind_t KIND_UNKNOWN = 5'd19;
  localparam kind_t KIND_EOF     = 5'd20;

  localparam logic [7:0] CH_LF         = 8'h0A;
  localparam logic [7:0] CH_SPACE      = 8'h20;
  localparam logic [7:0] CH_QUOTE      = 8'h22;
  localparam logic [7:0] CH_DOT        = 8'h2E;
  localparam logic [7:0] CH_SLASH      = 8'h2F;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;

  localparam logic [1:0] KW_VAR = 2'd0;
  localparam logic [1:0] KW_FUN = 2'd1;
  localparam logic [1:0] KW_RET = 2'd2;

  typedef struct packed {
    kind_t                  kind;
    logic [FIELD_BITS-1:0]  start;
    logic [FIELD_BITS-1:0]  length;
    logic [FIELD_BITS-1:0]  line;
  } token_t;

  typedef struct packed {
    token_t [MAX_TOKENS-1:0] tok;
    logic [1:0]              count;
  } token_batch_t;

  typedef struct packed {
    token_t tok;
    logic   last;
  } queue_entry_t;

  function automatic logic is_digit(logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  function automatic logic is_alpha(logic [7:0] b);
    return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
  endfunction

  function automatic logic is_space(logic [7:0] b);
    return (b == CH_SPACE) || ((b >= 8'h09) && (b <= 8'h0D));
  endfunction

  function automatic kind_t op_kind(logic [7:0] b);
    kind_t k;
    case (b)
      8'h2B:   k = KIND_PLUS;
      8'h2D:   k = KIND_MINUS;
      8'h2A:   k = KIND_STAR;
      8'h28:   k = KIND_LPAREN;
      8'h29:   k = KIND_RPAREN;
      8'h7B:   k = KIND_LBRACE;
      8'h7D:   k = KIND_RBRACE;
      8'h3B:   k = KIND_SEMI;
      8'h3D:   k = KIND_ASSIGN;
      8'h2C:   k = KIND_COMMA;
      default: k = KIND_UNKNOWN;
    endcase
    return k;
  endfunction

  function automatic logic [2:0] kw_len(logic [1:0] kw);
    logic [2:0] n;
    case (kw)
      KW_VAR:  n = 3'd3;
      KW_FUN:  n = 3'd3;
      KW_RET:  n = 3'd6;
      default: n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] kw_char(logic [1:0] kw, logic [2:0] idx);
    logic [7:0] c;
    c = 8'h00;
    case (kw)
      KW_VAR: begin
        case (idx)
          3'd0:    c = 8'h76;
          3'd1:    c = 8'h61;
          3'd2:    c = 8'h72;
          default: c = 8'h00;
        endcase
      end
      KW_FUN: begin
        case (idx)
          3'd0:    c = 8'h66;
          3'd1:    c = 8'h75;
          3'd2:    c = 8'h6E;
          default: c = 8'h00;
        endcase
      end
      KW_RET: begin
        case (idx)
          3'd0:    c = 8'h72;
          3'd1:    c = 8'h65;
          3'd2:    c = 8'h74;
          3'd3:    c = 8'h75;
          3'd4:    c = 8'h72;
          3'd5:    c = 8'h6E;
          default: c = 8'h00;
        endcase
      end
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ===== hdl/stt_if.sv =====
// Valid/ready channel interfaces for source bytes in and tokens out.
interface stt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] source_byte;
  logic       end_of_source;

  modport source (output valid, output source_byte, output end_of_source, input ready);
  modport sink (input valid, input source_byte, input end_of_source, output ready);
endinterface

interface stt_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  token_kind;
  logic [23:0] token_start;
  logic [23:0] token_length;
  logic [23:0] token_line;
  logic        last_of_run;

  modport source (
    output valid, output token_kind, output token_start, output token_length,
    output token_line, output last_of_run, input ready
  );
  modport sink (
    input valid, input token_kind, input token_start, input token_length,
    input token_line, input last_of_run, output ready
  );
endinterface

// ===== hdl/stt_scanner.sv =====
// Lexer state registers and the single-pass logic that turns one request into up to three tokens.
module stt_scanner #(
  parameter int OFFSET_BITS = 24
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 accept,
  input  logic [7:0]           source_byte,
  input  logic                 end_of_source,
  output stt_pkg::token_batch_t batch
);
  import stt_pkg::*;

  typedef logic [OFFSET_BITS-1:0] off_t;
  typedef enum logic [2:0] {
    M_IDLE, M_INT, M_INTDOT, M_FLOAT, M_STRING, M_IDENT, M_SLASH
  } mode_t;

  localparam off_t OFF_MAX = '1;

  mode_t                 mode_r, mode_nxt;
  off_t                  origin_r, origin_nxt;
  off_t                  pos_r, pos_nxt;
  off_t                  len_r, len_nxt;
  logic [FIELD_BITS-1:0] line_r, line_nxt;
  logic [2:0]            kc_r, kc_nxt;

  mode_t                 fr_mode;
  off_t                  fr_origin, fr_len, fr_pos, fb_pos;
  logic [FIELD_BITS-1:0] fr_line, line_inc;
  logic [2:0]            fr_kc, kc_first, kc_step;
  logic                  fr_emit;
  logic                  is_idch;
  kind_t                 ident_kind;

  function automatic off_t sat_add(off_t v, logic [1:0] add);
    logic [OFFSET_BITS:0] s;
    s = {1'b0, v} + {{(OFFSET_BITS-1){1'b0}}, add};
    return s[OFFSET_BITS] ? OFF_MAX : s[OFFSET_BITS-1:0];
  endfunction

  function automatic logic [FIELD_BITS-1:0] to_field(off_t v);
    logic [OFFSET_BITS+FIELD_BITS-1:0] w;
    w = {{FIELD_BITS{1'b0}}, v};
    return w[FIELD_BITS-1:0];
  endfunction

  function automatic token_t make_tok(kind_t k, off_t s, off_t l, logic [FIELD_BITS-1:0] ln);
    token_t t;
    t.kind   = k;
    t.start  = to_field(s);
    t.length = to_field(l);
    t.line   = ln;
    return t;
  endfunction

  assign line_inc = (line_r != '1) ? line_r + 1'b1 : line_r;
  assign is_idch  = is_alpha(source_byte) || is_digit(source_byte) ||
                    (source_byte == CH_UNDERSCORE);
  assign fb_pos   = (mode_r == M_INTDOT) ? sat_add(pos_r, 2'd1) : pos_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      kc_first[k] = (source_byte == kw_char(2'(k), 3'd0));
      kc_step[k]  = kc_r[k] && (len_r < OFFSET_BITS'(kw_len(2'(k)))) &&
                    (source_byte == kw_char(2'(k), len_r[2:0]));
    end
  end

  always_comb begin
    ident_kind = KIND_IDENT;
    for (int k = 0; k < 3; k++) begin
      if (kc_r[k] && (len_r == OFFSET_BITS'(kw_len(2'(k))))) begin
        ident_kind = KIND_VAR + 5'(k);
      end
    end
  end

  // Scan of a byte that starts a new lexeme, at position fb_pos.
  always_comb begin
    fr_mode   = M_IDLE;
    fr_origin = origin_r;
    fr_len    = len_r;
    fr_kc     = kc_r;
    fr_pos    = sat_add(fb_pos, 2'd1);
    fr_line   = line_r;
    fr_emit   = 1'b0;
    if (is_space(source_byte)) begin
      if (source_byte == CH_LF) begin
        fr_line = line_inc;
      end
    end else if (is_digit(source_byte)) begin
      fr_origin = fb_pos;
      fr_len    = OFFSET_BITS'(1);
      fr_mode   = M_INT;
    end else if (source_byte == CH_QUOTE) begin
      fr_origin = sat_add(fb_pos, 2'd1);
      fr_len    = '0;
      fr_mode   = M_STRING;
    end else if (is_alpha(source_byte) || (source_byte == CH_UNDERSCORE)) begin
      fr_origin = fb_pos;
      fr_len    = OFFSET_BITS'(1);
      fr_kc     = kc_first;
      fr_mode   = M_IDENT;
    end else if (source_byte == CH_SLASH) begin
      fr_origin = fb_pos;
      fr_mode   = M_SLASH;
    end else begin
      fr_emit = 1'b1;
    end
  end

  always_comb begin
    logic [1:0] n;
    logic       use_fresh;
    off_t       eof_pos;
    n          = 2'd0;
    use_fresh  = 1'b0;
    eof_pos    = pos_r;
    batch      = '0;
    mode_nxt   = mode_r;
    origin_nxt = origin_r;
    pos_nxt    = pos_r;
    len_nxt    = len_r;
    line_nxt   = line_r;
    kc_nxt     = kc_r;
    if (accept) begin
      if (end_of_source) begin
        unique case (mode_r)
          M_INT: begin
            batch.tok[n] = make_tok(KIND_INT, origin_r, len_r, line_r);
            n = n + 2'd1;
          end
          M_INTDOT: begin
            batch.tok[n] = make_tok(KIND_INT, origin_r, len_r, line_r);
            n = n + 2'd1;
            batch.tok[n] = make_tok(KIND_UNKNOWN, pos_r, OFFSET_BITS'(1), line_r);
            n = n + 2'd1;
            eof_pos = sat_add(pos_r, 2'd1);
          end
          M_FLOAT: begin
            batch.tok[n] = make_tok(KIND_FLOAT, origin_r, len_r, line_r);
            n = n + 2'd1;
          end
          M_STRING: begin
            batch.tok[n] = make_tok(KIND_STRING, origin_r, len_r, line_r);
            n = n + 2'd1;
          end
          M_IDENT: begin
            batch.tok[n] = make_tok(ident_kind, origin_r, len_r, line_r);
            n = n + 2'd1;
          end
          M_SLASH: begin
            batch.tok[n] = make_tok(KIND_SLASH, origin_r, OFFSET_BITS'(1), line_r);
            n = n + 2'd1;
          end
          default: ;
        endcase
        batch.tok[n] = make_tok(KIND_EOF, eof_pos, '0, line_r);
        n = n + 2'd1;
        mode_nxt   = M_IDLE;
        origin_nxt = '0;
        pos_nxt    = '0;
        len_nxt    = '0;
        line_nxt   = FIELD_BITS'(1);
        kc_nxt     = 3'b111;
      end else begin
        unique case (mode_r)
          M_INT: begin
            if (is_digit(source_byte)) begin
              len_nxt = sat_add(len_r, 2'd1);
              pos_nxt = sat_add(pos_r, 2'd1);
            end else if (source_byte == CH_DOT) begin
              mode_nxt = M_INTDOT;
            end else begin
              batch.tok[n] = make_tok(KIND_INT, origin_r, len_r, line_r);
              n = n + 2'd1;
              use_fresh = 1'b1;
            end
          end
          M_INTDOT: begin
            if (is_digit(source_byte)) begin
              len_nxt  = sat_add(len_r, 2'd2);
              pos_nxt  = sat_add(pos_r, 2'd2);
              mode_nxt = M_FLOAT;
            end else begin
              batch.tok[n] = make_tok(KIND_INT, origin_r, len_r, line_r);
              n = n + 2'd1;
              batch.tok[n] = make_tok(KIND_UNKNOWN, pos_r, OFFSET_BITS'(1), line_r);
              n = n + 2'd1;
              use_fresh = 1'b1;
            end
          end
          M_FLOAT: begin
            if (is_digit(source_byte)) begin
              len_nxt = sat_add(len_r, 2'd1);
              pos_nxt = sat_add(pos_r, 2'd1);
            end else begin
              batch.tok[n] = make_tok(KIND_FLOAT, origin_r, len_r, line_r);
              n = n + 2'd1;
              use_fresh = 1'b1;
            end
          end
          M_STRING: begin
            pos_nxt = sat_add(pos_r, 2'd1);
            if (source_byte == CH_QUOTE) begin
              batch.tok[n] = make_tok(KIND_STRING, origin_r, len_r, line_r);
              n = n + 2'd1;
              mode_nxt = M_IDLE;
            end else begin
              if (source_byte == CH_LF) begin
                line_nxt = line_inc;
              end
              len_nxt = sat_add(len_r, 2'd1);
            end
          end
          M_IDENT: begin
            if (is_idch) begin
              kc_nxt  = kc_step;
              len_nxt = sat_add(len_r, 2'd1);
              pos_nxt = sat_add(pos_r, 2'd1);
            end else begin
              batch.tok[n] = make_tok(ident_kind, origin_r, len_r, line_r);
              n = n + 2'd1;
              use_fresh = 1'b1;
            end
          end
          M_SLASH: begin
            if (source_byte == CH_SLASH) begin
              batch.tok[n] = make_tok(KIND_SLASH2, origin_r, OFFSET_BITS'(2), line_r);
              n = n + 2'd1;
              pos_nxt  = sat_add(pos_r, 2'd1);
              mode_nxt = M_IDLE;
            end else begin
              batch.tok[n] = make_tok(KIND_SLASH, origin_r, OFFSET_BITS'(1), line_r);
              n = n + 2'd1;
              use_fresh = 1'b1;
            end
          end
          default: begin
            use_fresh = 1'b1;
          end
        endcase
        if (use_fresh) begin
          mode_nxt   = fr_mode;
          origin_nxt = fr_origin;
          len_nxt    = fr_len;
          kc_nxt     = fr_kc;
          pos_nxt    = fr_pos;
          line_nxt   = fr_line;
          if (fr_emit) begin
            batch.tok[n] = make_tok(op_kind(source_byte), fb_pos, OFFSET_BITS'(1), line_r);
            n = n + 2'd1;
          end
        end
      end
    end
    batch.count = n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= M_IDLE;
      origin_r <= '0;
      pos_r    <= '0;
      len_r    <= '0;
      line_r   <= FIELD_BITS'(1);
      kc_r     <= 3'b111;
    end else begin
      mode_r   <= mode_nxt;
      origin_r <= origin_nxt;
      pos_r    <= pos_nxt;
      len_r    <= len_nxt;
      line_r   <= line_nxt;
      kc_r     <= kc_nxt;
    end
  end

endmodule

// ===== hdl/stt_token_queue.sv =====
// Three-entry result queue that holds the tokens of one request and hands them out in order.
module stt_token_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  load,
  input  stt_pkg::token_batch_t batch,
  input  logic                  out_ready,
  output logic                  can_load,
  output logic                  out_valid,
  output stt_pkg::queue_entry_t head
);
  import stt_pkg::*;

  queue_entry_t [MAX_TOKENS-1:0] ent_r, ent_nxt;
  logic [1:0]                    cnt_r, cnt_nxt;
  logic                          pop;

  assign out_valid = (cnt_r != 2'd0);
  assign pop       = out_valid && out_ready;
  assign can_load  = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_ready);
  assign head      = ent_r[0];

  always_comb begin
    ent_nxt = ent_r;
    cnt_nxt = cnt_r;
    if (load) begin
      cnt_nxt = batch.count;
      for (int i = 0; i < MAX_TOKENS; i++) begin
        ent_nxt[i].tok  = batch.tok[i];
        ent_nxt[i].last = (2'(i) == batch.count - 2'd1);
      end
    end else if (pop) begin
      cnt_nxt = cnt_r - 2'd1;
      for (int i = 0; i < MAX_TOKENS - 1; i++) begin
        ent_nxt[i] = ent_r[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3 || !load)
    else $error("queue loaded while holding three tokens");

  a_load_ok: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> (cnt_r == 2'd0) || ((cnt_r == 2'd1) && pop))
    else $error("queue loaded over undelivered tokens");

  a_pop_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !load) |=> cnt_r == $past(cnt_r) - 2'd1)
    else $error("queue count did not drop after a pop");

  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd1) |-> ent_r[0].last)
    else $error("final queued token lacks its last flag");

endmodule

// ===== hdl/source_text_tokenizer_unit.sv =====
// Top level of the streaming source text tokenizer.
//
//   channel  direction  payload
//   in_ch    sink       source_byte[7:0], end_of_source
//   out_ch   source     token_kind[4:0], token_start, token_length, token_line, last_of_run
//
// A request is scanned in the cycle it is accepted and its tokens land in a three-entry queue.
// A request that yields zero or one token is accepted every cycle while out_ch drains.
// A request that yields more than one token holds in_ch until only its last token remains and out_ch is ready.
// Reset is synchronous and active low; an end-of-source request also returns the scanner
// to its reset state.
module source_text_tokenizer_unit #(
  parameter int OFFSET_BITS = 24
) (
  input  logic   clk,
  input  logic   rst_n,
  stt_in_if.sink   in_ch,
  stt_out_if.source out_ch
);
  import stt_pkg::*;

  token_batch_t batch;
  queue_entry_t head;
  logic         can_load;
  logic         accept;

  assign in_ch.ready = can_load;
  assign accept      = in_ch.valid && can_load;

  stt_scanner #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_scanner (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .source_byte   (in_ch.source_byte),
    .end_of_source (in_ch.end_of_source),
    .batch         (batch)
  );

  stt_token_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (accept),
    .batch     (batch),
    .out_ready (out_ch.ready),
    .can_load  (can_load),
    .out_valid (out_ch.valid),
    .head      (head)
  );

  assign out_ch.token_kind   = head.tok.kind;
  assign out_ch.token_start  = head.tok.start;
  assign out_ch.token_length = head.tok.length;
  assign out_ch.token_line   = head.tok.line;
  assign out_ch.last_of_run  = head.last;

endmodule
